// File: rtl/stbl_pkg.sv
// Package for the shared token bucket limiter: widths, codes and payload types.
package stbl_pkg;

	localparam int MAX_SLOTS_DEF        = 16;
	localparam int TICKS_PER_SECOND_DEF = 4;

	localparam int AW   = 24;  // allowance, limit and byte widths
	localparam int DVW  = 32;  // shared divider width
	localparam int CFGW = 1;   // register index width

	// register indexes
	localparam logic [CFGW-1:0] REG_LIMIT_DOWNLOAD = 1'd0;
	localparam logic [CFGW-1:0] REG_LIMIT_UPLOAD   = 1'd1;

	// commands
	localparam logic [2:0] CMD_TICK       = 3'd0;
	localparam logic [2:0] CMD_APPEND     = 3'd1;
	localparam logic [2:0] CMD_REMOVE_ALL = 3'd2;
	localparam logic [2:0] CMD_REMOVE_ONE = 3'd3;
	localparam logic [2:0] CMD_USAGE      = 3'd4;

	typedef struct packed {
		logic [2:0]    command;
		logic [3:0]    slot;
		logic          direction;
		logic [AW-1:0] byte_count;
	} in_item_t;

	typedef struct packed {
		logic [3:0]    slot_echo;
		logic [AW-1:0] allowance;
		logic          unlimited;
		logic          timer_running;
	} out_item_t;

endpackage

// File: rtl/shared_token_bucket_limiter.sv
// Top level of the shared token bucket limiter with fair share redistribution.
//
// Usage: commands arrive on the in_valid/in_ready channel (tick, append,
// remove both, remove one, usage); every command yields exactly one result
// transfer on out_valid/out_ready reporting the slot's allowance, its
// unlimited flag and whether the tick timer runs. Limits are written through
// cfg_we/cfg_index/cfg_data; the user must do so only while the block is
// idle, and the block does not enforce it. One command is taken at a time;
// in_ready is high only while idle. An append with a zero limit marks the
// slot unlimited without a division; a remove divides only for a direction
// where the slot is listed; a stopped tick and an unknown command only report.
// A running tick handles each direction in turn: a zero limit marks its
// members unlimited, no members skips it, else the limit is divided by the
// ticks and the tokens by the members, every slot is walked in turn, and
// rounds spread overflow over open members. These divisions and the limit by
// ticks times members of append and remove use the one shared radix-2 divider.
// The result sits in an output register: a new command is accepted while it
// waits, and the block holds the next result until the receiver takes it.
// Reset: all slots unlimited, nothing listed, debts and limits zero, timer
// stopped. The allowance memory needs no clearing pass: an entry is always
// written as its slot leaves the unlimited state.
module shared_token_bucket_limiter #(
	parameter int MAX_SLOTS        = stbl_pkg::MAX_SLOTS_DEF,
	parameter int TICKS_PER_SECOND = stbl_pkg::TICKS_PER_SECOND_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  stbl_pkg::in_item_t        in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output stbl_pkg::out_item_t       out_data,
	input  logic                      cfg_we,
	input  logic [stbl_pkg::CFGW-1:0] cfg_index,
	input  logic [stbl_pkg::AW-1:0]   cfg_data
);

	localparam int AW  = stbl_pkg::AW;
	localparam int DVW = stbl_pkg::DVW;
	localparam int SW  = $clog2(MAX_SLOTS);
	localparam int CW  = $clog2(MAX_SLOTS + 1);
	localparam int DCW = $clog2(DVW + 1);

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_DIV     = 5'd1;
	localparam logic [4:0] S_USE_RD  = 5'd2;
	localparam logic [4:0] S_USE_WR  = 5'd3;
	localparam logic [4:0] S_REP_RD  = 5'd4;
	localparam logic [4:0] S_REP     = 5'd5;
	localparam logic [4:0] S_APP     = 5'd6;
	localparam logic [4:0] S_APP_WR  = 5'd7;
	localparam logic [4:0] S_RM      = 5'd8;
	localparam logic [4:0] S_RM_DEBT = 5'd9;
	localparam logic [4:0] S_TICK    = 5'd10;
	localparam logic [4:0] S_TD      = 5'd11;
	localparam logic [4:0] S_TPER    = 5'd12;
	localparam logic [4:0] S_WRD     = 5'd13;
	localparam logic [4:0] S_WWR     = 5'd14;
	localparam logic [4:0] S_RND     = 5'd15;
	localparam logic [4:0] S_RSH     = 5'd16;
	localparam logic [4:0] S_TNEXT   = 5'd17;
	localparam logic [4:0] S_TTOK    = 5'd18;

	logic [4:0]           state_q, dv_ret_q;
	logic [2:0]           cmd_q;
	logic [3:0]           slot_q;
	logic [AW-1:0]        bytes_q;
	logic                 cur_d_q;
	logic                 ok_q;
	logic [AW-1:0]        lim_q [2];
	logic [AW-1:0]        debt_q [2];
	logic [CW-1:0]        cnt_q [2];
	logic [MAX_SLOTS-1:0] lst_q [2];
	logic [MAX_SLOTS-1:0] unl_q, open_q;
	logic                 ticking_q;
	logic [SW-1:0]        ptr_q;
	logic                 round_q;
	logic [CW-1:0]        nopen_q;
	logic [DVW-1:0]       spill_q, add_q;
	logic [AW-1:0]        cap_q;
	logic [DVW-1:0]       dv_rem_q, dv_quo_q, dv_den_q;
	logic [DCW-1:0]       dv_cnt_q;
	logic                 out_valid_q;
	stbl_pkg::out_item_t  out_q;

	logic [AW-1:0] mem [MAX_SLOTS];
	logic [AW-1:0] rd_q;

	// slot decode
	logic [31:0]   slot_ext, in_slot_ext;
	logic [SW-1:0] si;
	assign slot_ext    = 32'(slot_q);
	assign in_slot_ext = 32'(in_data.slot);
	assign si          = slot_ext[SW-1:0];

	// per direction quantities; limit / ticks / members is limit / (ticks * members)
	logic [AW-1:0]  lim;
	logic [CW-1:0]  cnt, cnt_new;
	logic           lst_si;
	logic [DVW-1:0] den_cur, den_app, tok;
	assign lim     = lim_q[cur_d_q];
	assign cnt     = cnt_q[cur_d_q];
	assign lst_si  = lst_q[cur_d_q][si];
	assign cnt_new = lst_si ? cnt : cnt + CW'(1);
	assign den_cur = DVW'(cnt) * DVW'(TICKS_PER_SECOND);
	assign den_app = DVW'(cnt_new) * DVW'(TICKS_PER_SECOND);
	// divider quotient floored at one: tokens per tick, then share per member
	assign tok     = (dv_quo_q == '0) ? DVW'(1) : dv_quo_q;

	// shared divider step
	logic [DVW:0] dv_sh;
	logic         dv_ge;
	assign dv_sh = {dv_rem_q, dv_quo_q[DVW-1]};
	assign dv_ge = dv_sh >= {1'b0, dv_den_q};

	// walk adder and compare
	logic [DVW:0] vsum, ovf;
	logic         over;
	assign vsum = {{(DVW-AW+1){1'b0}}, rd_q} + {1'b0, add_q};
	assign over = vsum > {{(DVW-AW+1){1'b0}}, cap_q};
	assign ovf  = vsum - {{(DVW-AW+1){1'b0}}, cap_q};

	// append share less debt
	logic [AW-1:0] app_share, quo24, debt;
	assign quo24 = dv_quo_q[AW-1:0];
	assign debt  = debt_q[cur_d_q];
	always_comb begin
		app_share = quo24;
		if (debt != '0) begin
			app_share = (quo24 >= debt) ? quo24 - debt : '0;
		end
	end

	// remove debt accrual, saturating
	logic [AW:0] debt_sum;
	assign debt_sum = {1'b0, debt} + {1'b0, quo24 - rd_q};

	// result load into the output register
	logic rep_load;
	assign rep_load = (state_q == S_REP) && (!out_valid_q || out_ready);

	// memory address and write port
	logic [SW-1:0] raddr;
	logic          mem_we;
	logic [AW-1:0] mem_wd;
	logic [SW-1:0] mem_wa;
	always_comb begin
		raddr  = (state_q == S_WRD) ? ptr_q : si;
		mem_we = 1'b0;
		mem_wa = si;
		mem_wd = '0;
		case (state_q)
			S_USE_WR: begin
				mem_we = ok_q && !unl_q[si];
				mem_wd = (bytes_q > rd_q) ? '0 : rd_q - bytes_q;
			end
			S_APP_WR: begin
				mem_we = 1'b1;
				mem_wd = app_share;
			end
			S_WWR: begin
				mem_wa = ptr_q;
				if (!round_q) begin
					mem_we = lst_q[cur_d_q][ptr_q];
					mem_wd = unl_q[ptr_q] ? add_q[AW-1:0] : (over ? cap_q : vsum[AW-1:0]);
				end else begin
					mem_we = open_q[ptr_q];
					mem_wd = over ? cap_q : vsum[AW-1:0];
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// allowance memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[raddr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q[0] <= '0;
			lim_q[1] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				stbl_pkg::REG_LIMIT_DOWNLOAD: lim_q[0] <= cfg_data;
				stbl_pkg::REG_LIMIT_UPLOAD:   lim_q[1] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dv_ret_q    <= S_IDLE;
			debt_q[0]   <= '0;
			debt_q[1]   <= '0;
			cnt_q[0]    <= '0;
			cnt_q[1]    <= '0;
			lst_q[0]    <= '0;
			lst_q[1]    <= '0;
			unl_q       <= '1;
			open_q      <= '0;
			ticking_q   <= 1'b0;
			out_valid_q <= 1'b0;
			dv_cnt_q    <= '0;
		end else begin
			if (rep_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q   <= in_data.command;
						slot_q  <= in_data.slot;
						bytes_q <= in_data.byte_count;
						ok_q    <= in_slot_ext < MAX_SLOTS;
						cur_d_q <= (in_data.command == stbl_pkg::CMD_REMOVE_ALL ||
							in_data.command == stbl_pkg::CMD_TICK) ? 1'b0 : in_data.direction;
						if (in_data.command == stbl_pkg::CMD_TICK) begin
							state_q <= S_TICK;
						end else if (in_slot_ext >= MAX_SLOTS) begin
							state_q <= S_REP_RD;
						end else begin
							case (in_data.command)
								stbl_pkg::CMD_APPEND:     state_q <= S_APP;
								stbl_pkg::CMD_REMOVE_ALL: state_q <= S_RM;
								stbl_pkg::CMD_REMOVE_ONE: state_q <= S_RM;
								stbl_pkg::CMD_USAGE:      state_q <= S_USE_RD;
								default:                  state_q <= S_REP_RD;
							endcase
						end
					end
				end
				S_DIV: begin
					dv_quo_q <= {dv_quo_q[DVW-2:0], dv_ge};
					dv_rem_q <= dv_ge ? DVW'(dv_sh - {1'b0, dv_den_q}) : dv_sh[DVW-1:0];
					dv_cnt_q <= dv_cnt_q - DCW'(1);
					if (dv_cnt_q == DCW'(1)) begin
						state_q <= dv_ret_q;
					end
				end
				S_USE_RD: state_q <= S_USE_WR;
				S_USE_WR: state_q <= S_REP_RD;
				S_REP_RD: state_q <= S_REP;
				S_REP: begin
					if (rep_load) begin
						out_q.slot_echo     <= slot_q;
						out_q.allowance     <= (!ok_q || unl_q[si]) ? '0 : rd_q;
						out_q.unlimited     <= !ok_q || unl_q[si];
						out_q.timer_running <= ticking_q;
						state_q             <= S_IDLE;
					end
				end
				// append: list first, then share over the new member count
				S_APP: begin
					lst_q[cur_d_q][si] <= 1'b1;
					cnt_q[cur_d_q]     <= cnt_new;
					ticking_q          <= 1'b1;
					if (lim == '0) begin
						unl_q[si] <= 1'b1;
						state_q   <= S_REP_RD;
					end else begin
						dv_quo_q <= DVW'(lim);
						dv_rem_q <= '0;
						dv_den_q <= den_app;
						dv_cnt_q <= DCW'(DVW);
						dv_ret_q <= S_APP_WR;
						state_q  <= S_DIV;
					end
				end
				S_APP_WR: begin
					unl_q[si] <= 1'b0;
					if (debt != '0 && quo24 >= debt) begin
						debt_q[cur_d_q] <= '0;
					end
					state_q <= S_REP_RD;
				end
				// remove: share counted with the slot still listed
				S_RM: begin
					if (lst_si) begin
						dv_quo_q <= DVW'(lim);
						dv_rem_q <= '0;
						dv_den_q <= den_cur;
						dv_cnt_q <= DCW'(DVW);
						dv_ret_q <= S_RM_DEBT;
						state_q  <= S_DIV;
					end else begin
						unl_q[si] <= 1'b1;
						if (cmd_q == stbl_pkg::CMD_REMOVE_ALL && !cur_d_q) begin
							cur_d_q <= 1'b1;
						end else begin
							state_q <= S_REP_RD;
						end
					end
				end
				S_RM_DEBT: begin
					if (!unl_q[si] && rd_q < quo24) begin
						debt_q[cur_d_q] <= debt_sum[AW] ? '1 : debt_sum[AW-1:0];
					end
					lst_q[cur_d_q][si] <= 1'b0;
					cnt_q[cur_d_q]     <= cnt - CW'(1);
					unl_q[si]          <= 1'b1;
					if (cmd_q == stbl_pkg::CMD_REMOVE_ALL && !cur_d_q) begin
						cur_d_q <= 1'b1;
						state_q <= S_RM;
					end else begin
						state_q <= S_REP_RD;
					end
				end
				// tick
				S_TICK: state_q <= ticking_q ? S_TD : S_REP_RD;
				S_TD: begin
					debt_q[cur_d_q] <= '0;
					if (lim == '0) begin
						unl_q   <= unl_q | lst_q[cur_d_q];
						state_q <= S_TNEXT;
					end else if (cnt == '0) begin
						state_q <= S_TNEXT;
					end else begin
						dv_quo_q <= DVW'(lim);
						dv_rem_q <= '0;
						dv_den_q <= DVW'(TICKS_PER_SECOND);
						dv_cnt_q <= DCW'(DVW);
						dv_ret_q <= S_TTOK;
						state_q  <= S_DIV;
					end
				end
				// tokens known: set the cap, then split over the members
				S_TTOK: begin
					cap_q    <= AW'(tok * DVW'(TICKS_PER_SECOND));
					dv_quo_q <= tok;
					dv_rem_q <= '0;
					dv_den_q <= DVW'(cnt);
					dv_cnt_q <= DCW'(DVW);
					dv_ret_q <= S_TPER;
					state_q  <= S_DIV;
				end
				S_TPER: begin
					add_q   <= tok;
					spill_q <= '0;
					nopen_q <= '0;
					ptr_q   <= '0;
					round_q <= 1'b0;
					state_q <= S_WRD;
				end
				S_WRD: state_q <= S_WWR;
				S_WWR: begin
					if (!round_q) begin
						if (lst_q[cur_d_q][ptr_q]) begin
							if (unl_q[ptr_q]) begin
								unl_q[ptr_q]  <= 1'b0;
								open_q[ptr_q] <= 1'b1;
								nopen_q       <= nopen_q + CW'(1);
							end else if (over) begin
								spill_q       <= spill_q + ovf[DVW-1:0];
								open_q[ptr_q] <= 1'b0;
							end else begin
								open_q[ptr_q] <= 1'b1;
								nopen_q       <= nopen_q + CW'(1);
							end
						end else begin
							open_q[ptr_q] <= 1'b0;
						end
					end else if (open_q[ptr_q] && over) begin
						spill_q       <= spill_q + ovf[DVW-1:0];
						open_q[ptr_q] <= 1'b0;
						nopen_q       <= nopen_q - CW'(1);
					end
					ptr_q <= ptr_q + SW'(1);
					state_q <= (ptr_q == SW'(MAX_SLOTS - 1)) ? S_RND : S_WRD;
				end
				S_RND: begin
					if (spill_q != '0 && nopen_q != '0) begin
						dv_quo_q <= spill_q;
						dv_rem_q <= '0;
						dv_den_q <= DVW'(nopen_q);
						dv_cnt_q <= DCW'(DVW);
						dv_ret_q <= S_RSH;
						state_q  <= S_DIV;
					end else begin
						state_q <= S_TNEXT;
					end
				end
				S_RSH: begin
					if (dv_quo_q == '0) begin
						state_q <= S_TNEXT;
					end else begin
						add_q   <= dv_quo_q;
						spill_q <= '0;
						ptr_q   <= '0;
						round_q <= 1'b1;
						state_q <= S_WRD;
					end
				end
				S_TNEXT: begin
					if (!cur_d_q) begin
						cur_d_q <= 1'b1;
						state_q <= S_TD;
					end else begin
						ticking_q <= (cnt_q[0] != '0) || (cnt_q[1] != '0);
						state_q   <= S_REP_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	// one command at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("command accepted while busy");
	// a stopped timer means no slot is listed
	a_timer_members: assert property (@(posedge clk) disable iff (!arst_n)
		!ticking_q |-> (cnt_q[0] == '0) && (cnt_q[1] == '0))
		else $error("timer stopped with members listed");
	// results come only from the report step
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_REP)
		else $error("result raised outside report step");
`endif

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the shared token bucket limiter.
`timescale 1ns / 1ps

module testbench;

	localparam int NSLOT = stbl_pkg::MAX_SLOTS_DEF;
	localparam int TPS = stbl_pkg::TICKS_PER_SECOND_DEF;
	localparam int AW = stbl_pkg::AW;
	localparam int CFGW = stbl_pkg::CFGW;
	localparam int MAX_CYCLES = 4000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	stbl_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	stbl_pkg::out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [CFGW-1:0] cfg_index = '0;
	logic [AW-1:0] cfg_data = '0;

	shared_token_bucket_limiter dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predictor state
	logic [AW-1:0] lim [2];
	logic [AW-1:0] alw [NSLOT];
	bit unl [NSLOT];
	bit lst [2][NSLOT];
	logic [AW-1:0] debt [2];
	bit ticking;

	stbl_pkg::in_item_t cmd_queue[$];
	stbl_pkg::out_item_t expected_results[$];
	int sender_idle_pct, receiver_idle_pct;
	int mismatches;
	longint cycles;
	bit in_taken = 1'b0;

	function automatic int members(int d);
		int n = 0;
		for (int s = 0; s < NSLOT; s++) if (lst[d][s]) n++;
		return n;
	endfunction

	function automatic void tick_dir(int d);
		longint tokens, cap, per, spill, sh, v;
		int n, nopen;
		bit open_s [NSLOT];
		spill = 0;
		nopen = 0;
		debt[d] = '0;
		if (lim[d] == 0) begin
			for (int s = 0; s < NSLOT; s++)
				if (lst[d][s]) begin
					unl[s] = 1;
					alw[s] = '0;
				end
			return;
		end
		n = members(d);
		if (n == 0) return;
		tokens = lim[d] / TPS;
		if (tokens == 0) tokens = 1;
		cap = tokens * TPS;
		per = tokens / n;
		if (per == 0) per = 1;
		for (int s = 0; s < NSLOT; s++) begin
			open_s[s] = 0;
			if (!lst[d][s]) continue;
			if (unl[s]) begin
				unl[s] = 0;
				alw[s] = AW'(per);
				open_s[s] = 1;
				nopen++;
			end else begin
				v = longint'(alw[s]) + per;
				if (v > cap) begin
					spill += v - cap;
					alw[s] = AW'(cap);
				end else begin
					alw[s] = AW'(v);
					open_s[s] = 1;
					nopen++;
				end
			end
		end
		// redistribute overflow in rounds
		while (spill != 0 && nopen != 0) begin
			sh = spill / nopen;
			if (sh == 0) break;
			spill = 0;
			for (int s = 0; s < NSLOT; s++) begin
				if (!open_s[s]) continue;
				v = longint'(alw[s]) + sh;
				if (v > cap) begin
					spill += v - cap;
					alw[s] = AW'(cap);
					open_s[s] = 0;
					nopen--;
				end else begin
					alw[s] = AW'(v);
				end
			end
		end
	endfunction

	function automatic void append_member(int s, int d);
		longint share;
		lst[d][s] = 1;
		if (lim[d] > 0) begin
			share = (lim[d] / TPS) / members(d);
			if (debt[d] > 0) begin
				if (share >= debt[d]) begin
					share -= debt[d];
					debt[d] = '0;
				end else begin
					share = 0;
				end
			end
			alw[s] = AW'(share);
			unl[s] = 0;
		end else begin
			alw[s] = '0;
			unl[s] = 1;
		end
		ticking = 1;
	endfunction

	function automatic void remove_member(int s, int d);
		longint share, v;
		if (lst[d][s]) begin
			share = (lim[d] / TPS) / members(d);
			if (!unl[s] && alw[s] < share) begin
				v = longint'(debt[d]) + (share - alw[s]);
				debt[d] = (v > 64'hFFFFFF) ? '1 : AW'(v);
			end
			lst[d][s] = 0;
		end
		unl[s] = 1;
		alw[s] = '0;
	endfunction

	function automatic stbl_pkg::out_item_t predict_allowance(stbl_pkg::in_item_t it);
		stbl_pkg::out_item_t r;
		int s;
		s = it.slot;
		case (it.command)
			stbl_pkg::CMD_TICK: begin
				if (ticking) begin
					tick_dir(0);
					tick_dir(1);
					if (members(0) == 0 && members(1) == 0) ticking = 0;
				end
			end
			stbl_pkg::CMD_APPEND: append_member(s, it.direction);
			stbl_pkg::CMD_REMOVE_ALL: begin
				remove_member(s, 0);
				remove_member(s, 1);
			end
			stbl_pkg::CMD_REMOVE_ONE: remove_member(s, it.direction);
			stbl_pkg::CMD_USAGE: begin
				if (!unl[s])
					alw[s] = (it.byte_count > alw[s]) ? '0 : alw[s] - it.byte_count;
			end
			default: ;
		endcase
		r.slot_echo = it.slot;
		r.allowance = unl[s] ? '0 : alw[s];
		r.unlimited = unl[s];
		r.timer_running = ticking;
		return r;
	endfunction

	// Driver: predicts on each accepted transfer
	always @(posedge clk) begin
		in_taken <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			expected_results.push_back(predict_allowance(in_data));
			void'(cmd_queue.pop_front());
		end
	end

	// Driver: valid stays up until the transfer has been taken
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (cmd_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
				in_valid <= 1'b1;
				in_data <= cmd_queue[0];
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stalls and monitor
	always @(negedge clk)
		out_ready <= arst_n && ($urandom_range(99) >= receiver_idle_pct);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", out_data);
			end else begin
				if (out_data !== expected_results[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected slot %0d alw %0d unl %0b tmr %0b,",
							" got slot %0d alw %0d unl %0b tmr %0b"},
							expected_results[0].slot_echo, expected_results[0].allowance,
							expected_results[0].unlimited, expected_results[0].timer_running,
							out_data.slot_echo, out_data.allowance,
							out_data.unlimited, out_data.timer_running);
				end
				void'(expected_results.pop_front());
			end
		end
		if (cycles > MAX_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic push_cmd(int c, int s, int d, int b);
		stbl_pkg::in_item_t it;
		it.command = 3'(c);
		it.slot = 4'(s);
		it.direction = 1'(d);
		it.byte_count = AW'(b);
		cmd_queue.push_back(it);
	endtask

	task automatic drain();
		while (cmd_queue.size() > 0 || expected_results.size() > 0) @(posedge clk);
		repeat (2000) @(posedge clk);
	endtask

	task automatic write_limit(logic [CFGW-1:0] idx, logic [AW-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		lim[idx] = v;
	endtask

	// Random command mix: mostly usage and membership changes, some ticks
	task automatic random_cmds(int n);
		int k;
		int b;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			b = ($urandom_range(3) == 0) ? $urandom : $urandom_range(3000);
			if (k < 12)
				push_cmd(stbl_pkg::CMD_TICK, $urandom_range(15), $urandom_range(1), $urandom);
			else if (k < 40)
				push_cmd(stbl_pkg::CMD_APPEND, $urandom_range(15), $urandom_range(1), b);
			else if (k < 50)
				push_cmd(stbl_pkg::CMD_REMOVE_ALL, $urandom_range(15), $urandom_range(1), b);
			else if (k < 62)
				push_cmd(stbl_pkg::CMD_REMOVE_ONE, $urandom_range(15), $urandom_range(1), b);
			else if (k < 96)
				push_cmd(stbl_pkg::CMD_USAGE, $urandom_range(15), $urandom_range(1), b);
			else
				push_cmd($urandom_range(7, 5), $urandom_range(15), $urandom_range(1), b);
		end
	endtask

	initial begin
		logic [AW-1:0] settings [6][2];
		settings = '{'{24'd0, 24'd0}, '{24'd1000, 24'd3}, '{24'hFFFFFF, 24'd1},
			'{24'd7, 24'hFFFFFF}, '{24'd40000, 24'd0}, '{24'd2, 24'd100}};
		mismatches = 0;
		cycles = 0;
		sender_idle_pct = 20;
		receiver_idle_pct = 74;
		lim = '{default: '0};
		alw = '{default: '0};
		unl = '{default: 1'b1};
		lst = '{default: '{default: 1'b0}};
		debt = '{default: '0};
		ticking = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: ticks while stopped, append, debts, usage extremes, bad commands
		write_limit(stbl_pkg::REG_LIMIT_DOWNLOAD, 24'd4000);
		write_limit(stbl_pkg::REG_LIMIT_UPLOAD, 24'd0);
		push_cmd(stbl_pkg::CMD_TICK, 0, 0, 0);
		push_cmd(stbl_pkg::CMD_USAGE, 15, 1, 24'hFFFFFF);
		push_cmd(stbl_pkg::CMD_APPEND, 0, 0, 0);
		push_cmd(stbl_pkg::CMD_APPEND, 1, 0, 0);
		push_cmd(stbl_pkg::CMD_APPEND, 2, 1, 0);
		push_cmd(stbl_pkg::CMD_USAGE, 0, 0, 24'd100);
		push_cmd(stbl_pkg::CMD_USAGE, 1, 0, 24'hFFFFFF);
		push_cmd(stbl_pkg::CMD_REMOVE_ONE, 1, 0, 0);
		push_cmd(stbl_pkg::CMD_APPEND, 3, 0, 0);
		push_cmd(stbl_pkg::CMD_APPEND, 3, 0, 0);
		push_cmd(stbl_pkg::CMD_TICK, 5, 1, 0);
		push_cmd(stbl_pkg::CMD_TICK, 5, 1, 0);
		push_cmd(stbl_pkg::CMD_TICK, 5, 1, 0);
		push_cmd(stbl_pkg::CMD_TICK, 5, 1, 0);
		push_cmd(stbl_pkg::CMD_TICK, 5, 1, 0);
		push_cmd(stbl_pkg::CMD_USAGE, 0, 0, 24'd0);
		push_cmd(stbl_pkg::CMD_REMOVE_ALL, 0, 0, 0);
		push_cmd(5, 3, 1, 24'h555555);
		push_cmd(7, 15, 0, 24'hAAAAAA);
		push_cmd(stbl_pkg::CMD_REMOVE_ALL, 3, 0, 0);
		push_cmd(stbl_pkg::CMD_REMOVE_ALL, 2, 1, 0);
		push_cmd(stbl_pkg::CMD_TICK, 0, 0, 0);
		push_cmd(stbl_pkg::CMD_TICK, 0, 0, 0);
		drain();

		// Random phases over several limit settings and idle profiles
		for (int p = 0; p < 6; p++) begin
			if (p == 2) begin
				sender_idle_pct = 74;
				receiver_idle_pct = 20;
			end else if (p == 4) begin
				sender_idle_pct = 0;
				receiver_idle_pct = 0;
			end
			write_limit(stbl_pkg::REG_LIMIT_DOWNLOAD, settings[p][0]);
			write_limit(stbl_pkg::REG_LIMIT_UPLOAD, settings[p][1]);
			random_cmds(250);
			drain();
		end

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
